// File: sv/hbrq_pkg.sv
`timescale 1ns / 1ps
// types and constants for the retry queue
package hbrq_pkg;

    localparam int ID_W       = 64;
    localparam int THR_W      = 7;
    localparam int CFG_DATA_W = 7;
    localparam int QCOUNT_W   = 7;

    localparam logic [THR_W-1:0] UPPER_RESET = 7'd48;
    localparam logic [THR_W-1:0] LOWER_RESET = 7'd16;

    // event kinds
    localparam logic FUNC_FAIL    = 1'b0;
    localparam logic FUNC_SUCCESS = 1'b1;

    // configuration register indexes
    localparam logic REG_UPPER = 1'b0;
    localparam logic REG_LOWER = 1'b1;

    typedef struct packed {
        logic        func;
        logic [15:0] origin_id;
        logic [31:0] sequence_number;
        logic [15:0] chunk_number;
    } cmd_t;

    typedef struct packed {
        logic                emit_valid;
        logic [15:0]         emit_origin_id;
        logic [31:0]         emit_sequence_number;
        logic [15:0]         emit_chunk_number;
        logic                apply_pressure;
        logic                release_pressure;
        logic                pressure_active;
        logic [QCOUNT_W-1:0] queue_count;
        logic                queue_empty;
        logic                overflow;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

endpackage

// File: sv/hbrq_ram.sv
`timescale 1ns / 1ps
// generic single-port-write, single-port-read ram with registered read
module hbrq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/hysteresis_backpressure_retry_queue.sv
`timescale 1ns / 1ps
// retry queue with hysteresis backpressure: top level
//
// usage
// an item (sink event: send failed or send succeeded, with the buffer id) is
// taken at a rising edge where start is high and busy is low. busy is high
// in the work state that follows, while the item is worked on.
// exactly one result per item appears on result, marked by done for a single
// cycle; done and result are registered at the end of the work state. the
// next item may be taken while done is high, but not while busy is high.
// the work state is there for the queue memory: the head entry is read at the
// accepting edge (registered read), then the pop, push and pressure decision
// are made and the tail entry written at the next edge.
// thresholds are written through cfg_we / cfg_index / cfg_data while idle;
// the larger of the two acts as the upper threshold, the smaller as the lower.
// reset clears pointers, count, pending flag and the pressure flag and loads
// the threshold defaults; the queue memory needs no clearing since only
// counted entries are read. done cannot be held off by the receiver.
module hysteresis_backpressure_retry_queue
    import hbrq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  cmd_t                  cmd,
    output logic                  done,
    output result_t               result,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW   = $clog2(QUEUE_DEPTH);
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int VW   = CW + 1;
    localparam int CMPW = (VW > THR_W) ? VW : THR_W;
    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

    state_t            state_reg, state_next;
    logic [THR_W-1:0]  upper_reg, lower_reg;
    cmd_t              cmd_reg;
    logic [AW-1:0]     head_reg, head_next;
    logic [AW-1:0]     tail_reg, tail_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]   pend_id_reg, pend_id_next;
    logic              press_reg, press_next;
    logic              done_reg;
    result_t           result_reg, result_next;

    logic              accept;
    logic              exec;
    logic [ID_W-1:0]   head_data;
    logic [ID_W-1:0]   in_id;
    logic [ID_W-1:0]   emitted;
    logic [THR_W-1:0]  thr_hi, thr_lo;
    logic [VW-1:0]     virt;
    logic              match, full, empty;
    logic              do_push, do_pop;
    logic              emit, apply, release_p, ovf;

    assign accept = start && !busy;
    assign busy   = state_reg[1];
    assign exec   = (state_reg == ST_EXEC);

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + AW'(1);
    endfunction

    hbrq_ram #(
        .WIDTH (ID_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (do_push),
        .waddr (tail_reg),
        .wdata (in_id),
        .re    (accept),
        .raddr (head_reg),
        .rdata (head_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= UPPER_RESET;
            lower_reg <= LOWER_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_UPPER: upper_reg <= THR_W'(cfg_data);
                REG_LOWER: lower_reg <= THR_W'(cfg_data);
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_EXEC;
            ST_EXEC: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign in_id  = {cmd_reg.origin_id, cmd_reg.sequence_number, cmd_reg.chunk_number};
    assign thr_hi = (upper_reg > lower_reg) ? upper_reg : lower_reg;
    assign thr_lo = (upper_reg > lower_reg) ? lower_reg : upper_reg;
    assign match  = pend_valid_reg && (pend_id_reg == in_id);
    assign full   = (count_reg == FULL_COUNT);
    assign empty  = (count_reg == '0);

    always_comb
    begin
        emit            = 1'b0;
        emitted         = '0;
        apply           = 1'b0;
        release_p       = 1'b0;
        ovf             = 1'b0;
        do_push         = 1'b0;
        do_pop          = 1'b0;
        virt            = '0;
        press_next      = press_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        if (exec)
        begin
            if (cmd_reg.func == FUNC_FAIL)
            begin
                if (match)
                begin
                    emit    = 1'b1;
                    emitted = in_id;
                end
                else
                begin
                    ovf  = pend_valid_reg && full;
                    // count as seen by the pressure check
                    virt = ovf ? VW'(count_reg) : VW'(count_reg) + VW'(1);
                    if (!press_reg && (CMPW'(virt) >= CMPW'(thr_hi)))
                    begin
                        apply      = 1'b1;
                        press_next = 1'b1;
                    end
                    if (!pend_valid_reg)
                    begin
                        if (empty)
                        begin
                            emitted = in_id;
                        end
                        else
                        begin
                            emitted = head_data;
                            do_pop  = 1'b1;
                            do_push = 1'b1;
                        end
                        emit            = 1'b1;
                        pend_valid_next = 1'b1;
                        pend_id_next    = emitted;
                    end
                    else if (!ovf)
                    begin
                        do_push = 1'b1;
                    end
                end
            end
            else if (match)
            begin
                pend_valid_next = 1'b0;
                pend_id_next    = '0;
                if (press_reg && (CMPW'(count_reg) <= CMPW'(thr_lo)))
                begin
                    release_p  = 1'b1;
                    press_next = 1'b0;
                end
                if (!empty)
                begin
                    emitted         = head_data;
                    emit            = 1'b1;
                    do_pop          = 1'b1;
                    pend_valid_next = 1'b1;
                    pend_id_next    = head_data;
                end
            end
        end
    end

    assign head_next  = do_pop  ? next_slot(head_reg) : head_reg;
    assign tail_next  = do_push ? next_slot(tail_reg) : tail_reg;
    assign count_next = count_reg + CW'(do_push) - CW'(do_pop);

    always_comb
    begin
        result_next.emit_valid           = emit;
        result_next.emit_origin_id       = emitted[63:48];
        result_next.emit_sequence_number = emitted[47:16];
        result_next.emit_chunk_number    = emitted[15:0];
        result_next.apply_pressure       = apply;
        result_next.release_pressure     = release_p;
        result_next.pressure_active      = press_next;
        result_next.queue_count          = QCOUNT_W'(count_next);
        result_next.queue_empty          = (count_next == '0);
        result_next.overflow             = ovf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            press_reg      <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            press_reg      <= press_next;
            done_reg       <= exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        pend_id_reg <= pend_id_next;
        if (exec)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // the count never goes past the memory depth
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FULL_COUNT)
        else $error("queue count above depth");

    // a result always follows a work cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_EXEC))
        else $error("result without a work cycle");

    // an emitted id becomes the pending id
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.emit_valid) |-> pend_valid_reg)
        else $error("emit without pending id");

    // a drop only happens with the queue full
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.overflow) |-> (count_reg == FULL_COUNT))
        else $error("overflow with room in queue");

    // memory is written only in the work cycle
    assert property (@(posedge clk) disable iff (!rst_n) do_push |-> exec)
        else $error("queue write outside work cycle");

endmodule
